// File: sv/ppb_pkg.sv
package ppb_pkg;

   typedef enum logic [1:0] {
      CMD_CLEAR       = 2'd0,
      CMD_LOAD_WORKER = 2'd1,
      CMD_LOAD_PART   = 2'd2,
      CMD_BALANCE     = 2'd3
   } cmd_type;

   // One stored worker record: offered cores (zero when not running) and the
   // cpu taken outside the framework.
   typedef struct packed {
      logic [7:0]         cores;
      logic signed [16:0] stolen;
   } worker_rec_type;

   // One result item as it leaves the block.
   typedef struct packed {
      logic       move_valid;
      logic [5:0] moved_partition;
      logic [3:0] target_slot;
      logic       last_move;
   } rsp_item_type;

endpackage

// File: sv/ppb_ram.sv
module ppb_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: sv/ppb_seq.sv
module ppb_seq
   import ppb_pkg::*;
#(
   parameter int MAX_WORKERS    = 16,
   parameter int MAX_PARTITIONS = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         straggler_mode,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [1:0]   req_cmd,
   input  logic [3:0]   req_worker_slot,
   input  logic         req_is_running,
   input  logic [7:0]   req_core_count,
   input  logic [15:0]  req_total_cpu_use,
   input  logic [15:0]  req_framework_cpu_use,
   input  logic [5:0]   req_partition_index,
   input  logic         out_free,
   output logic         push,
   output rsp_item_type push_item
);

   localparam int WW = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
   localparam int PW = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
   localparam int OW = (WW > 4) ? WW : 4;
   localparam int CW = $clog2(MAX_PARTITIONS + 1);
   localparam int TW = $clog2(MAX_WORKERS * 255 + 1);
   localparam int RW = $bits(worker_rec_type);

   localparam logic [WW-1:0] W_LAST = WW'(MAX_WORKERS - 1);
   localparam logic [PW-1:0] P_LAST = PW'(MAX_PARTITIONS - 1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_SUM, ST_CNT_P, ST_CNT_H, ST_STRIP, ST_DIV, ST_QUO, ST_REM,
      ST_DON, ST_CHK, ST_TGT, ST_PSCAN, ST_EMIT, ST_WB, ST_FINAL
   } state_type;

   state_type            state_ff, state_in;
   logic                 ph_ff, ph_in;
   logic [WW-1:0]        wa_ff, wa_in;
   logic [PW-1:0]        pa_ff, pa_in;
   logic [WW-1:0]        w_ff, w_in;
   logic [WW-1:0]        c_ff, c_in;
   logic [TW-1:0]        total_ff, total_in;
   logic [CW-1:0]        parts_ff, parts_in;
   logic [CW-1:0]        per_ff, per_in;
   logic [CW-1:0]        rem_ff, rem_in;
   logic signed [16:0]   best_ff, best_in;
   logic [WW-1:0]        bw_ff, bw_in;
   logic [7:0]           bcores_ff, bcores_in;
   logic                 found_ff, found_in;
   logic                 strip_ff, strip_in;
   logic [CW-1:0]        cur_held_ff, cur_held_in;
   logic [CW-1:0]        cur_quota_ff, cur_quota_in;
   logic [CW-1:0]        c_held_ff, c_held_in;
   logic [CW-1:0]        nmoves_ff, nmoves_in;
   logic                 pend_valid_ff, pend_valid_in;
   logic [5:0]           pend_p_ff, pend_p_in;
   logic [3:0]           pend_c_ff, pend_c_in;
   logic [5:0]           mv_p_ff, mv_p_in;
   logic [3:0]           mv_c_ff, mv_c_in;
   logic [MAX_WORKERS-1:0]    present_ff, present_in;
   logic [MAX_PARTITIONS-1:0] pvalid_ff, pvalid_in;

   logic                 wrec_we;
   logic [WW-1:0]        wrec_wa;
   worker_rec_type       wrec_wd, wrec_rd;
   logic [RW-1:0]        wrec_rd_raw;
   logic                 quota_we;
   logic [CW-1:0]        quota_wd, quota_rd;
   logic                 held_we;
   logic [WW-1:0]        held_wa;
   logic [CW-1:0]        held_wd, held_rd;
   logic                 part_we;
   logic [PW-1:0]        part_wa;
   logic [OW-1:0]        part_wd, part_rd;

   logic [7:0]           eff_cores;
   logic [TW-1:0]        total_strip;
   logic [CW-1:0]        rem_dec;
   logic [WW-1:0]        wa_wrap;
   logic                 accept;
   logic [WW-1:0]        slot_idx;
   logic [WW-1:0]        owner_idx;
   logic [7+CW:0]        quota_prod;

   ppb_ram #(.DEPTH(MAX_WORKERS), .WIDTH(RW)) u_wrec (
      .clock(clock), .we(wrec_we), .waddr(wrec_wa), .wdata(wrec_wd),
      .raddr(wa_ff), .rdata(wrec_rd_raw)
   );
   ppb_ram #(.DEPTH(MAX_WORKERS), .WIDTH(CW)) u_quota (
      .clock(clock), .we(quota_we), .waddr(wa_ff), .wdata(quota_wd),
      .raddr(wa_ff), .rdata(quota_rd)
   );
   ppb_ram #(.DEPTH(MAX_WORKERS), .WIDTH(CW)) u_held (
      .clock(clock), .we(held_we), .waddr(held_wa), .wdata(held_wd),
      .raddr(wa_ff), .rdata(held_rd)
   );
   ppb_ram #(.DEPTH(MAX_PARTITIONS), .WIDTH(OW)) u_part (
      .clock(clock), .we(part_we), .waddr(part_wa), .wdata(part_wd),
      .raddr(pa_ff), .rdata(part_rd)
   );

   assign wrec_rd   = worker_rec_type'(wrec_rd_raw);
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign slot_idx  = WW'(req_worker_slot);
   assign owner_idx = WW'(part_rd);

   // A worker stripped as straggler, or not present, offers no cores.
   assign eff_cores = (present_ff[wa_ff] && !(strip_ff && (wa_ff == bw_ff)))
                      ? wrec_rd.cores : 8'd0;
   assign total_strip = (total_ff != '0 && straggler_mode && found_ff)
                        ? total_ff - TW'(bcores_ff) : total_ff;
   assign rem_dec    = rem_ff - CW'(1);
   assign wa_wrap    = (wa_ff == W_LAST) ? '0 : wa_ff + WW'(1);
   assign quota_prod = eff_cores * per_ff;

   always_comb begin
      state_in      = state_ff;
      ph_in         = ph_ff;
      wa_in         = wa_ff;
      pa_in         = pa_ff;
      w_in          = w_ff;
      c_in          = c_ff;
      total_in      = total_ff;
      parts_in      = parts_ff;
      per_in        = per_ff;
      rem_in        = rem_ff;
      best_in       = best_ff;
      bw_in         = bw_ff;
      bcores_in     = bcores_ff;
      found_in      = found_ff;
      strip_in      = strip_ff;
      cur_held_in   = cur_held_ff;
      cur_quota_in  = cur_quota_ff;
      c_held_in     = c_held_ff;
      nmoves_in     = nmoves_ff;
      pend_valid_in = pend_valid_ff;
      pend_p_in     = pend_p_ff;
      pend_c_in     = pend_c_ff;
      mv_p_in       = mv_p_ff;
      mv_c_in       = mv_c_ff;
      present_in    = present_ff;
      pvalid_in     = pvalid_ff;

      wrec_we  = 1'b0;
      wrec_wa  = slot_idx;
      wrec_wd.cores  = req_is_running ? req_core_count : 8'd0;
      wrec_wd.stolen = $signed({1'b0, req_total_cpu_use})
                       - $signed({1'b0, req_framework_cpu_use});
      quota_we = 1'b0;
      quota_wd = CW'(quota_prod);
      held_we  = 1'b0;
      held_wa  = wa_ff;
      held_wd  = '0;
      part_we  = 1'b0;
      part_wa  = PW'(req_partition_index);
      part_wd  = OW'(req_worker_slot);

      push      = 1'b0;
      push_item = '{move_valid: pend_valid_ff, moved_partition: pend_p_ff,
                    target_slot: pend_c_ff, last_move: 1'b0};

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (cmd_type'(req_cmd))
                  CMD_CLEAR: begin
                     present_in = '0;
                     pvalid_in  = '0;
                  end
                  CMD_LOAD_WORKER: begin
                     if (32'(req_worker_slot) < MAX_WORKERS) begin
                        present_in[slot_idx] = 1'b1;
                        wrec_we = 1'b1;
                     end
                  end
                  CMD_LOAD_PART: begin
                     if (32'(req_partition_index) < MAX_PARTITIONS) begin
                        pvalid_in[PW'(req_partition_index)] = 1'b1;
                        part_we = 1'b1;
                     end
                  end
                  default: begin
                     state_in      = ST_SUM;
                     ph_in         = 1'b0;
                     wa_in         = '0;
                     total_in      = '0;
                     parts_in      = '0;
                     found_in      = 1'b0;
                     strip_in      = 1'b0;
                     nmoves_in     = '0;
                     pend_valid_in = 1'b0;
                     pend_p_in     = '0;
                     pend_c_in     = '0;
                  end
               endcase
            end
         end

         // Sum the cores, clear held counts and track the top cpu stealer.
         ST_SUM: begin
            ph_in = ~ph_ff;
            if (ph_ff) begin
               held_we = 1'b1;
               if (present_ff[wa_ff]) begin
                  total_in = total_ff + TW'(wrec_rd.cores);
                  if (!found_ff || (wrec_rd.stolen > best_ff)) begin
                     found_in  = 1'b1;
                     best_in   = wrec_rd.stolen;
                     bw_in     = wa_ff;
                     bcores_in = wrec_rd.cores;
                  end
               end
               if (wa_ff == W_LAST) begin
                  state_in = ST_CNT_P;
                  pa_in    = '0;
               end else begin
                  wa_in = wa_ff + WW'(1);
               end
            end
         end

         ST_CNT_P: begin
            ph_in = ~ph_ff;
            if (ph_ff) begin
               if (pvalid_ff[pa_ff] && (32'(part_rd) < MAX_WORKERS) &&
                   present_ff[owner_idx]) begin
                  state_in = ST_CNT_H;
                  wa_in    = owner_idx;
               end else if (pa_ff == P_LAST) begin
                  state_in = ST_STRIP;
               end else begin
                  pa_in = pa_ff + PW'(1);
               end
            end
         end

         ST_CNT_H: begin
            ph_in = ~ph_ff;
            if (ph_ff) begin
               held_we  = 1'b1;
               held_wd  = held_rd + CW'(1);
               parts_in = parts_ff + CW'(1);
               if (pa_ff == P_LAST) begin
                  state_in = ST_STRIP;
               end else begin
                  state_in = ST_CNT_P;
                  pa_in    = pa_ff + PW'(1);
               end
            end
         end

         ST_STRIP: begin
            total_in = total_strip;
            strip_in = (total_ff != '0) && straggler_mode && found_ff;
            rem_in   = parts_ff;
            per_in   = '0;
            state_in = (total_strip == '0) ? ST_FINAL : ST_DIV;
         end

         // Quotient by repeated subtraction; the parts count is small.
         ST_DIV: begin
            if (TW'(rem_ff) >= total_ff) begin
               rem_in = CW'(TW'(rem_ff) - total_ff);
               per_in = per_ff + CW'(1);
            end else begin
               state_in = ST_QUO;
               wa_in    = '0;
               ph_in    = 1'b0;
            end
         end

         ST_QUO: begin
            ph_in = ~ph_ff;
            if (ph_ff) begin
               quota_we = 1'b1;
               if (wa_ff == W_LAST) begin
                  wa_in = '0;
                  w_in  = '0;
                  state_in = (rem_ff != '0) ? ST_REM : ST_DON;
               end else begin
                  wa_in = wa_ff + WW'(1);
               end
            end
         end

         ST_REM: begin
            ph_in = ~ph_ff;
            if (ph_ff) begin
               if (eff_cores != 8'd0) begin
                  quota_we = 1'b1;
                  quota_wd = quota_rd + CW'(1);
                  rem_in   = rem_dec;
               end
               if ((eff_cores != 8'd0) && (rem_dec == '0)) begin
                  state_in = ST_DON;
                  wa_in    = '0;
                  w_in     = '0;
               end else begin
                  wa_in = wa_wrap;
               end
            end
         end

         ST_DON: begin
            ph_in = ~ph_ff;
            if (ph_ff) begin
               if (present_ff[w_ff]) begin
                  cur_held_in  = held_rd;
                  cur_quota_in = quota_rd;
                  state_in     = ST_CHK;
               end else if (w_ff == W_LAST) begin
                  state_in = ST_FINAL;
               end else begin
                  w_in  = w_ff + WW'(1);
                  wa_in = w_ff + WW'(1);
               end
            end
         end

         ST_CHK: begin
            if ((cur_held_ff > cur_quota_ff) &&
                (nmoves_ff < CW'(MAX_PARTITIONS))) begin
               state_in = ST_TGT;
               wa_in    = '0;
               ph_in    = 1'b0;
            end else begin
               state_in = ST_WB;
            end
         end

         ST_TGT: begin
            ph_in = ~ph_ff;
            if (ph_ff) begin
               if (present_ff[wa_ff] && (wa_ff != w_ff) && (held_rd < quota_rd)) begin
                  c_in      = wa_ff;
                  c_held_in = held_rd;
                  state_in  = ST_PSCAN;
                  pa_in     = '0;
               end else if (wa_ff == W_LAST) begin
                  state_in = ST_WB;
               end else begin
                  wa_in = wa_ff + WW'(1);
               end
            end
         end

         ST_PSCAN: begin
            ph_in = ~ph_ff;
            if (ph_ff) begin
               if (pvalid_ff[pa_ff] && (part_rd == OW'(w_ff))) begin
                  part_we     = 1'b1;
                  part_wa     = pa_ff;
                  part_wd     = OW'(c_ff);
                  held_we     = 1'b1;
                  held_wa     = c_ff;
                  held_wd     = c_held_ff + CW'(1);
                  cur_held_in = cur_held_ff - CW'(1);
                  nmoves_in   = nmoves_ff + CW'(1);
                  mv_p_in     = 6'(pa_ff);
                  mv_c_in     = 4'(c_ff);
                  state_in    = ST_EMIT;
               end else if (pa_ff == P_LAST) begin
                  state_in = ST_WB;
               end else begin
                  pa_in = pa_ff + PW'(1);
               end
            end
         end

         // The previous move leaves once the next one is known.
         ST_EMIT: begin
            if (!pend_valid_ff || out_free) begin
               push          = pend_valid_ff;
               pend_valid_in = 1'b1;
               pend_p_in     = mv_p_ff;
               pend_c_in     = mv_c_ff;
               state_in      = ST_CHK;
            end
         end

         ST_WB: begin
            held_we = 1'b1;
            held_wa = w_ff;
            held_wd = cur_held_ff;
            ph_in   = 1'b0;
            if (w_ff == W_LAST) begin
               state_in = ST_FINAL;
            end else begin
               state_in = ST_DON;
               w_in     = w_ff + WW'(1);
               wa_in    = w_ff + WW'(1);
            end
         end

         ST_FINAL: begin
            push_item.last_move = 1'b1;
            if (out_free) begin
               push     = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         present_ff <= '0;
         pvalid_ff  <= '0;
      end else begin
         state_ff   <= state_in;
         present_ff <= present_in;
         pvalid_ff  <= pvalid_in;
      end
      ph_ff         <= ph_in;
      wa_ff         <= wa_in;
      pa_ff         <= pa_in;
      w_ff          <= w_in;
      c_ff          <= c_in;
      total_ff      <= total_in;
      parts_ff      <= parts_in;
      per_ff        <= per_in;
      rem_ff        <= rem_in;
      best_ff       <= best_in;
      bw_ff         <= bw_in;
      bcores_ff     <= bcores_in;
      found_ff      <= found_in;
      strip_ff      <= strip_in;
      cur_held_ff   <= cur_held_in;
      cur_quota_ff  <= cur_quota_in;
      c_held_ff     <= c_held_in;
      nmoves_ff     <= nmoves_in;
      pend_valid_ff <= pend_valid_in;
      pend_p_ff     <= pend_p_in;
      pend_c_ff     <= pend_c_in;
      mv_p_ff       <= mv_p_in;
      mv_c_ff       <= mv_c_in;
   end

endmodule

// File: sv/core_proportional_partition_balancer.sv
// Partition balancer. Load items fill a table of worker records and a table
// of partition owners; a clear item empties both, and a balance item computes
// per-worker quotas in proportion to cores and then emits one result item per
// partition move, the last one flagged, or a single empty item when nothing
// moves. Load and clear items are handled in the idle state and do not stall
// the input. A balance item runs through one sequencer over tables with one
// write and one read port whose reads are registered, so each table visit
// has a read phase and a use phase. The run sums cores, counts holdings per
// partition slot, forms the quotient by repeated subtraction, sets quotas,
// hands out the remainder, and for each move searches the workers for a
// target and then the partitions for one to move. The input is stalled for
// the whole run. Results leave through an output register, so the sequencer
// keeps working while one finished item waits for the receiver.
module core_proportional_partition_balancer
   import ppb_pkg::*;
#(
   parameter int MAX_WORKERS    = 16,
   parameter int MAX_PARTITIONS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [3:0]  req_worker_slot,
   input  logic        req_is_running,
   input  logic [7:0]  req_core_count,
   input  logic [15:0] req_total_cpu_use,
   input  logic [15:0] req_framework_cpu_use,
   input  logic [5:0]  req_partition_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_move_valid,
   output logic [5:0]  rsp_moved_partition,
   output logic [3:0]  rsp_target_slot,
   output logic        rsp_last_move
);

   // The user must write the straggler mode register only while the block is idle; the block does not enforce it.
   logic         straggler_mode_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff, rsp_item_in;
   logic         out_free;
   logic         push;
   rsp_item_type push_item;

   ppb_seq #(
      .MAX_WORKERS(MAX_WORKERS),
      .MAX_PARTITIONS(MAX_PARTITIONS)
   ) u_seq (
      .clock(clock),
      .reset(reset),
      .straggler_mode(straggler_mode_ff),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_cmd(req_cmd),
      .req_worker_slot(req_worker_slot),
      .req_is_running(req_is_running),
      .req_core_count(req_core_count),
      .req_total_cpu_use(req_total_cpu_use),
      .req_framework_cpu_use(req_framework_cpu_use),
      .req_partition_index(req_partition_index),
      .out_free(out_free),
      .push(push),
      .push_item(push_item)
   );

   // The output register is free when empty or when its item leaves now.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (push) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         straggler_mode_ff <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            straggler_mode_ff <= csr_wr_data;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_move_valid      = rsp_item_ff.move_valid;
   assign rsp_moved_partition = rsp_item_ff.moved_partition;
   assign rsp_target_slot     = rsp_item_ff.target_slot;
   assign rsp_last_move       = rsp_item_ff.last_move;

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps

import ppb_pkg::*;

// Scoreboard for the partition balancer. It keeps its own copy of the worker
// and partition tables and the straggler mode, and on each balance item it
// computes the moves that the block must emit.
class balance_scoreboard;

   localparam int NW = 16;
   localparam int NP = 64;

   bit              straggler;
   bit              present [NW];
   int              cores_of [NW];
   int              stolen_of [NW];
   bit              part_ok [NP];
   int              owner_of [NP];
   rsp_item_type    pending_moves [$];
   int              errors;

   function void clear_tables();
      for (int w = 0; w < NW; w++) begin
         present[w] = 0;
         cores_of[w] = 0;
         stolen_of[w] = 0;
      end
      for (int p = 0; p < NP; p++) begin
         part_ok[p] = 0;
         owner_of[p] = 0;
      end
   endfunction

   function void set_mode(bit m);
      straggler = m;
   endfunction

   // Works out the moves of one balance run and queues them.
   function void plan_moves();
      int cores [NW];
      int quota [NW];
      int held [NW];
      int total_cores;
      int total_parts;
      int per;
      int rem;
      int best;
      int bw;
      int c;
      int p;
      int n;
      bit found;
      bit got;
      rsp_item_type r;
      total_cores = 0;
      total_parts = 0;
      n = 0;
      for (int w = 0; w < NW; w++) begin
         cores[w] = present[w] ? cores_of[w] : 0;
         total_cores += cores[w];
         quota[w] = 0;
         held[w] = 0;
      end
      for (int q = 0; q < NP; q++) begin
         if (part_ok[q] && present[owner_of[q]]) begin
            held[owner_of[q]]++;
            total_parts++;
         end
      end
      // In straggler mode the worker stealing the most cpu loses its cores;
      // ties go to the lowest slot.
      if (total_cores != 0 && straggler) begin
         found = 0;
         best = 0;
         bw = 0;
         for (int w = 0; w < NW; w++) begin
            if (present[w] && (!found || stolen_of[w] > best)) begin
               found = 1;
               best = stolen_of[w];
               bw = w;
            end
         end
         if (found) begin
            total_cores -= cores[bw];
            cores[bw] = 0;
         end
      end
      if (total_cores != 0) begin
         per = total_parts / total_cores;
         rem = total_parts % total_cores;
         for (int w = 0; w < NW; w++) quota[w] = cores[w] * per;
         while (rem != 0) begin
            for (int w = 0; w < NW && rem != 0; w++) begin
               if (cores[w] != 0) begin
                  quota[w]++;
                  rem--;
               end
            end
         end
         for (int w = 0; w < NW; w++) begin
            if (present[w]) begin
               while (held[w] > quota[w] && n < NP) begin
                  got = 0;
                  for (c = 0; c < NW; c++) begin
                     if (present[c] && held[c] < quota[c]) begin
                        got = 1;
                        break;
                     end
                  end
                  if (!got) break;
                  for (p = 0; p < NP; p++)
                     if (part_ok[p] && owner_of[p] == w) break;
                  if (p >= NP) break;
                  owner_of[p] = c;
                  held[w]--;
                  held[c]++;
                  r.move_valid = 1'b1;
                  r.moved_partition = p[5:0];
                  r.target_slot = c[3:0];
                  r.last_move = 1'b0;
                  pending_moves.push_back(r);
                  n++;
               end
            end
         end
      end
      if (n == 0) begin
         r = '0;
         r.last_move = 1'b1;
         pending_moves.push_back(r);
      end else begin
         pending_moves[pending_moves.size() - 1].last_move = 1'b1;
      end
   endfunction

   function void note_item(cmd_type cmd, logic [3:0] slot, logic running,
                           logic [7:0] ncores, logic [15:0] tot, logic [15:0] fw,
                           logic [5:0] pidx);
      case (cmd)
         CMD_CLEAR: begin
            clear_tables();
         end
         CMD_LOAD_WORKER: begin
            present[slot] = 1;
            cores_of[slot] = running ? int'(ncores) : 0;
            stolen_of[slot] = int'(tot) - int'(fw);
         end
         CMD_LOAD_PART: begin
            part_ok[pidx] = 1;
            owner_of[pidx] = slot;
         end
         default: begin
            plan_moves();
         end
      endcase
   endfunction

   function void check_move(rsp_item_type got);
      rsp_item_type exp;
      if (pending_moves.size() == 0) begin
         $error("unexpected result item %p", got);
         errors++;
         return;
      end
      exp = pending_moves.pop_front();
      if (got.move_valid !== exp.move_valid) begin
         $error("move_valid expected %0d actual %0d", exp.move_valid, got.move_valid);
         errors++;
      end
      if (got.moved_partition !== exp.moved_partition) begin
         $error("moved_partition expected %0d actual %0d", exp.moved_partition,
                got.moved_partition);
         errors++;
      end
      if (got.target_slot !== exp.target_slot) begin
         $error("target_slot expected %0d actual %0d", exp.target_slot, got.target_slot);
         errors++;
      end
      if (got.last_move !== exp.last_move) begin
         $error("last_move expected %0d actual %0d", exp.last_move, got.last_move);
         errors++;
      end
   endfunction
endclass

module tb_top;
   import ppb_pkg::*;

   // The limit allows for long balance runs in the worst case, since
   // each move searches the worker and partition tables.
   localparam int CYCLE_LIMIT = 3000000;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic        csr_wr_data;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_cmd;
   logic [3:0]  req_worker_slot;
   logic        req_is_running;
   logic [7:0]  req_core_count;
   logic [15:0] req_total_cpu_use;
   logic [15:0] req_framework_cpu_use;
   logic [5:0]  req_partition_index;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_move_valid;
   logic [5:0]  rsp_moved_partition;
   logic [3:0]  rsp_target_slot;
   logic        rsp_last_move;

   balance_scoreboard sb;
   int cycles;
   bit idle_runs;

   core_proportional_partition_balancer dut (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_cmd(req_cmd),
      .req_worker_slot(req_worker_slot),
      .req_is_running(req_is_running),
      .req_core_count(req_core_count),
      .req_total_cpu_use(req_total_cpu_use),
      .req_framework_cpu_use(req_framework_cpu_use),
      .req_partition_index(req_partition_index),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_move_valid(rsp_move_valid),
      .rsp_moved_partition(rsp_moved_partition),
      .rsp_target_slot(rsp_target_slot),
      .rsp_last_move(rsp_last_move)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The watchdog ends a hung run with the fail message.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("** core_proportional_partition_balancer: FAILED **");
         $finish;
      end
   end

   // Every result item accepted by the receiver is checked against the oldest
   // expected move.
   always @(posedge clock) begin
      rsp_item_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.move_valid = rsp_move_valid;
         got.moved_partition = rsp_moved_partition;
         got.target_slot = rsp_target_slot;
         got.last_move = rsp_last_move;
         sb.check_move(got);
      end
   end

   // The receiver stalls for a random gap before each item,
   // except in stretches where it runs flat out.
   initial begin
      int gap;
      rsp_stall = 1'b1;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = idle_runs ? 0 : $urandom_range(0, 9);
         repeat (gap) begin
            rsp_stall <= 1'b1;
            @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // Sends one item: a random gap, then valid held until the block accepts.
   // The item is noted in the scoreboard at the edge where it is taken.
   task automatic send_item(cmd_type cmd, logic [3:0] slot, logic running,
                            logic [7:0] ncores, logic [15:0] tot, logic [15:0] fw,
                            logic [5:0] pidx);
      int gap;
      gap = idle_runs ? 0 : $urandom_range(0, 9);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_worker_slot <= slot;
      req_is_running <= running;
      req_core_count <= ncores;
      req_total_cpu_use <= tot;
      req_framework_cpu_use <= fw;
      req_partition_index <= pidx;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_item(cmd, slot, running, ncores, tot, fw, pidx);
   endtask

   // Drops valid and waits until all expected results have arrived, plus a
   // margin so the block is idle before a register write.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_moves.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_mode(bit m);
      csr_wr_en <= 1'b1;
      csr_wr_data <= m;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.set_mode(m);
   endtask

   task automatic random_worker(int max_cores);
      send_item(CMD_LOAD_WORKER, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 7) != 0),
                8'($urandom_range(0, max_cores)), 16'($urandom), 16'($urandom),
                6'($urandom));
   endtask

   task automatic random_part(int max_slot);
      send_item(CMD_LOAD_PART, 4'($urandom_range(0, max_slot)), 1'($urandom),
                8'($urandom), 16'($urandom), 16'($urandom), 6'($urandom));
   endtask

   // One well-formed scenario: a usually cleared table filled with random
   // workers and partitions, followed by one or two balance items.
   task automatic scenario();
      int nw;
      int np;
      int maxc;
      nw = $urandom_range(1, 6);
      np = $urandom_range(1, 12);
      maxc = ($urandom_range(0, 9) == 0) ? 255 : 4;
      if ($urandom_range(0, 3) != 0)
         send_item(CMD_CLEAR, 4'($urandom), 1'($urandom), 8'($urandom), 16'($urandom),
                   16'($urandom), 6'($urandom));
      for (int i = 0; i < nw; i++) random_worker(maxc);
      for (int i = 0; i < np; i++) random_part($urandom_range(0, 3) == 0 ? 15 : 7);
      send_item(CMD_BALANCE, 4'($urandom), 1'($urandom), 8'($urandom), 16'($urandom),
                16'($urandom), 6'($urandom));
      if ($urandom_range(0, 2) == 0)
         send_item(CMD_BALANCE, 4'($urandom), 1'($urandom), 8'($urandom),
                   16'($urandom), 16'($urandom), 6'($urandom));
   endtask

   initial begin
      sb = new();
      sb.clear_tables();
      sb.set_mode(1'b0);
      sb.errors = 0;
      cycles = 0;
      idle_runs = 0;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = 1'b0;
      req_valid = 1'b0;
      req_cmd = CMD_CLEAR;
      req_worker_slot = '0;
      req_is_running = 1'b0;
      req_core_count = '0;
      req_total_cpu_use = '0;
      req_framework_cpu_use = '0;
      req_partition_index = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. Balance on empty tables gives the empty result.
      send_item(CMD_BALANCE, 4'd0, 1'b0, 8'd0, 16'd0, 16'd0, 6'd0);
      // Slot 0 holds every partition from a full-width load; slot 15 has the
      // maximum core count and cpu at the extremes, slot 3 is not running.
      send_item(CMD_LOAD_WORKER, 4'd0, 1'b1, 8'd1, 16'hFFFF, 16'd0, 6'h3F);
      send_item(CMD_LOAD_WORKER, 4'd15, 1'b1, 8'd255, 16'd0, 16'hFFFF, 6'd0);
      send_item(CMD_LOAD_WORKER, 4'd3, 1'b0, 8'd200, 16'd100, 16'd50, 6'd0);
      send_item(CMD_LOAD_PART, 4'd0, 1'b0, 8'd0, 16'd0, 16'd0, 6'd63);
      send_item(CMD_LOAD_PART, 4'd0, 1'b1, 8'hFF, 16'hFFFF, 16'hFFFF, 6'd0);
      send_item(CMD_LOAD_PART, 4'd0, 1'b0, 8'd0, 16'd0, 16'd0, 6'd5);
      // An orphan partition owned by an absent slot.
      send_item(CMD_LOAD_PART, 4'd9, 1'b0, 8'd0, 16'd0, 16'd0, 6'd7);
      send_item(CMD_BALANCE, 4'd0, 1'b0, 8'd0, 16'd0, 16'd0, 6'd0);
      // Reload a worker, then balance again.
      send_item(CMD_LOAD_WORKER, 4'd15, 1'b1, 8'd2, 16'd10, 16'd10, 6'd0);
      send_item(CMD_BALANCE, 4'd0, 1'b0, 8'd0, 16'd0, 16'd0, 6'd0);
      drain();
      // Straggler mode: the only worker with cores is the top stealer, so no
      // cores remain.
      write_mode(1'b1);
      send_item(CMD_CLEAR, 4'hF, 1'b1, 8'hFF, 16'hFFFF, 16'hFFFF, 6'h3F);
      send_item(CMD_LOAD_WORKER, 4'd2, 1'b1, 8'd4, 16'd900, 16'd100, 6'd0);
      send_item(CMD_LOAD_WORKER, 4'd5, 1'b0, 8'd4, 16'd100, 16'd900, 6'd0);
      send_item(CMD_LOAD_PART, 4'd5, 1'b0, 8'd0, 16'd0, 16'd0, 6'd1);
      send_item(CMD_BALANCE, 4'd0, 1'b0, 8'd0, 16'd0, 16'd0, 6'd0);
      // Tied stealers: the lower slot loses its cores.
      send_item(CMD_LOAD_WORKER, 4'd5, 1'b1, 8'd3, 16'd900, 16'd100, 6'd0);
      send_item(CMD_LOAD_PART, 4'd2, 1'b0, 8'd0, 16'd0, 16'd0, 6'd2);
      send_item(CMD_LOAD_PART, 4'd2, 1'b0, 8'd0, 16'd0, 16'd0, 6'd3);
      send_item(CMD_BALANCE, 4'd0, 1'b0, 8'd0, 16'd0, 16'd0, 6'd0);
      drain();
      write_mode(1'b0);

      // Random part: scenarios in phases that switch the mode, with some
      // stray items mixed in and stretches without idling.
      for (int phase = 0; phase < 5; phase++) begin
         idle_runs = (phase % 3 == 2);
         for (int s = 0; s < 6; s++) begin
            if ($urandom_range(0, 4) == 0) begin
               send_item(cmd_type'($urandom_range(0, 3)), 4'($urandom), 1'($urandom),
                         8'($urandom), 16'($urandom), 16'($urandom), 6'($urandom));
            end
            scenario();
         end
         drain();
         write_mode(phase[0] ? 1'b0 : 1'b1);
      end
      idle_runs = 0;
      drain();

      if (sb.errors == 0 && sb.pending_moves.size() == 0) begin
         $display("** core_proportional_partition_balancer: PASSED **");
      end else begin
         $display("** core_proportional_partition_balancer: FAILED **");
      end
      $finish;
   end
endmodule
